// ===== sv/srdh_pkg.sv =====
// Package of shared types and constants for the sprite record dedup set.
`timescale 1ns / 1ps
package srdh_pkg;

  localparam logic [31:0] FnvBasis = 32'd2166136261;
  localparam logic [31:0] FnvPrime = 32'd16777619;

  localparam logic [2:0] OutFrame = 3'd0;
  localparam logic [2:0] OutNew   = 3'd1;
  localparam logic [2:0] OutSlot  = 3'd2;
  localparam logic [2:0] OutFound = 3'd3;
  localparam logic [2:0] OutLost  = 3'd4;

  typedef enum logic [3:0] {
    StIdle, StClear, StFiltRd, StFiltChk, StHash, StProbeRd, StProbeTag,
    StRecRd, StRecChk, StStore, StDone
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic frame;
    logic clr_step;
    logic filt_rd;
    logic filt_wr;
    logic hash_step;
    logic probe_init;
    logic probe_rd;
    logic probe_next;
    logic rec_rd;
    logic store;
    logic set_lost;
    logic set_out;
    logic [2:0] out_code;
    logic out_rec;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_frame;
    logic wrap;
    logic clr_last;
    logic filt_hit;
    logic hash_last;
    logic tag_live;
    logic full;
    logic probe_last;
    logic rec_hit;
  } status_t;

endpackage

// ===== sv/sprite_record_dedup_hash_set.sv =====
// Top level of the per-frame sprite record deduplicating hash set.
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o | cmd .. chain_position
//   out     | output    | out_valid_o / out_ready_i | outcome .. overflow_flag
// The hash takes one byte per cycle, and the single table port is probed one entry at a time.
// A generation wrap clears the tag memories, one entry a cycle, over max(TABLE_SIZE,
// FILTER_SLOTS) entries. The same clearing pass runs once after reset.
// One request is in flight; a new one is taken only once the result is taken.
`timescale 1ns / 1ps
module sprite_record_dedup_hash_set import srdh_pkg::*; #(
  parameter int CAPACITY     = 128,
  parameter int TABLE_SIZE   = 256,
  parameter int FILTER_SLOTS = 128,
  parameter int GEN_BITS     = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [15:0] y_pos_i,
  input  logic [15:0] x_pos_i,
  input  logic [15:0] attributes_i,
  input  logic [7:0]  width_cells_i,
  input  logic [7:0]  height_cells_i,
  input  logic [7:0]  table_slot_i,
  input  logic [7:0]  chain_position_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  outcome_o,
  output logic [6:0]  entry_index_o,
  output logic [7:0]  captured_count_o,
  output logic        overflow_flag_o
);

  cmd_t    cmd;
  status_t status;

  srdh_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .status_i(status), .cmd_o(cmd)
  );

  srdh_datapath #(
    .CAPACITY(CAPACITY), .TABLE_SIZE(TABLE_SIZE),
    .FILTER_SLOTS(FILTER_SLOTS), .GEN_BITS(GEN_BITS)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .in_cmd_i(cmd_i), .in_y_pos_i(y_pos_i), .in_x_pos_i(x_pos_i),
    .in_attributes_i(attributes_i), .in_width_cells_i(width_cells_i),
    .in_height_cells_i(height_cells_i), .in_table_slot_i(table_slot_i),
    .in_chain_position_i(chain_position_i),
    .outcome_o, .entry_index_o, .captured_count_o, .overflow_flag_o
  );

endmodule

// ===== sv/srdh_datapath.sv =====
// Datapath: record registers, hash unit, tag stores, table and capture memories.
`timescale 1ns / 1ps
module srdh_datapath import srdh_pkg::*; #(
  parameter int CAPACITY     = 128,
  parameter int TABLE_SIZE   = 256,
  parameter int FILTER_SLOTS = 128,
  parameter int GEN_BITS     = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  input  logic        in_cmd_i,
  input  logic [15:0] in_y_pos_i,
  input  logic [15:0] in_x_pos_i,
  input  logic [15:0] in_attributes_i,
  input  logic [7:0]  in_width_cells_i,
  input  logic [7:0]  in_height_cells_i,
  input  logic [7:0]  in_table_slot_i,
  input  logic [7:0]  in_chain_position_i,
  output logic [2:0]  outcome_o,
  output logic [6:0]  entry_index_o,
  output logic [7:0]  captured_count_o,
  output logic        overflow_flag_o
);

  localparam int TW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int FW = (FILTER_SLOTS > 1) ? $clog2(FILTER_SLOTS) : 1;
  localparam int CW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int NW = $clog2(TABLE_SIZE + 1);
  localparam int CLRW = (TW > FW) ? TW : FW;
  localparam int CLRN = (TABLE_SIZE > FILTER_SLOTS) ? TABLE_SIZE : FILTER_SLOTS;

  // Input request registers.
  logic        cmd_q;
  logic [15:0] y_q, x_q, a_q;
  logic [7:0]  w_q, h_q, s_q, c_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= in_cmd_i;
      y_q <= in_y_pos_i;
      x_q <= in_x_pos_i;
      a_q <= in_attributes_i;
      w_q <= in_width_cells_i;
      h_q <= in_height_cells_i;
      s_q <= in_table_slot_i;
      c_q <= in_chain_position_i;
    end
  end
  logic [71:0] ident;
  assign ident = {y_q, x_q, a_q, w_q, h_q, c_q};

  // Frame state: generation, count, lost flag, clear counter.
  logic [GEN_BITS-1:0] gen_q;
  logic [7:0]          cnt_q;
  logic                lost_q;
  logic [CLRW:0]       clr_q;
  logic [GEN_BITS-1:0] gen_inc;
  assign gen_inc = gen_q + 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q  <= GEN_BITS'(1);
      cnt_q  <= '0;
      lost_q <= 1'b0;
      clr_q  <= '0;
    end else begin
      if (cmd_i.frame) begin
        cnt_q  <= '0;
        lost_q <= 1'b0;
        gen_q  <= (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;
        clr_q  <= '0;
      end
      if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.store) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.set_lost) lost_q <= 1'b1;
    end
  end

  // Filter memories.
  logic [GEN_BITS-1:0] ftag_mem [FILTER_SLOTS];
  logic [71:0]         fid_mem [FILTER_SLOTS];
  logic [GEN_BITS-1:0] ftag_q;
  logic [71:0]         fid_q;
  logic [FW-1:0]       fi;
  assign fi = (FILTER_SLOTS > 1) ? FW'(s_q % FILTER_SLOTS) : '0;
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step && clr_q < (CLRW+1)'(FILTER_SLOTS)) ftag_mem[clr_q[FW-1:0]] <= '0;
    else if (cmd_i.filt_wr) begin
      ftag_mem[fi] <= gen_q;
      fid_mem[fi]  <= ident;
    end
    if (cmd_i.filt_rd) begin
      ftag_q <= ftag_mem[fi];
      fid_q  <= fid_mem[fi];
    end
  end

  // FNV-1a hash, one byte per cycle.
  logic [31:0] hash_q;
  logic [3:0]  bidx_q;
  logic [7:0]  hbyte;
  logic [31:0] hmix;
  always_comb begin
    case (bidx_q)
      4'd0: hbyte = y_q[7:0];
      4'd1: hbyte = y_q[15:8];
      4'd2: hbyte = x_q[7:0];
      4'd3: hbyte = x_q[15:8];
      4'd4: hbyte = a_q[7:0];
      4'd5: hbyte = a_q[15:8];
      4'd6: hbyte = w_q;
      4'd7: hbyte = h_q;
      4'd8: hbyte = s_q;
      default: hbyte = c_q;
    endcase
    hmix = (hash_q ^ {24'd0, hbyte}) * FnvPrime;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hash_q <= FnvBasis;
      bidx_q <= '0;
    end else if (cmd_i.hash_step) begin
      hash_q <= hmix;
      bidx_q <= bidx_q + 1'b1;
    end
  end
  logic [31:0] folded;
  assign folded = hash_q ^ {16'd0, hash_q[31:16]};

  // Probe position and counter.
  logic [TW-1:0] pos_q;
  logic [NW-1:0] np_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.probe_init) begin
      pos_q <= (TABLE_SIZE > 1) ? TW'(folded % TABLE_SIZE) : '0;
      np_q  <= '0;
    end else if (cmd_i.probe_next) begin
      pos_q <= (32'(pos_q) + 32'd1 >= TABLE_SIZE) ? '0 : pos_q + 1'b1;
      np_q  <= np_q + 1'b1;
    end
  end

  // Bucket tag and pointer memories.
  logic [GEN_BITS-1:0] btag_mem [TABLE_SIZE];
  logic [CW:0]         bptr_mem [TABLE_SIZE];
  logic [GEN_BITS-1:0] btag_q;
  logic [CW:0]         bptr_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step && clr_q < (CLRW+1)'(TABLE_SIZE)) btag_mem[clr_q[TW-1:0]] <= '0;
    else if (cmd_i.store) begin
      btag_mem[pos_q] <= gen_q;
      bptr_mem[pos_q] <= (CW+1)'(cnt_q);
    end
    if (cmd_i.probe_rd) begin
      btag_q <= btag_mem[pos_q];
      bptr_q <= bptr_mem[pos_q];
    end
  end

  // Capture list memory.
  logic [79:0] rec_mem [CAPACITY];
  logic [79:0] rec_q;
  logic        ptr_ok;
  assign ptr_ok = 32'(bptr_q) < CAPACITY;
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) rec_mem[cnt_q[CW-1:0]] <= {ident, s_q};
    if (cmd_i.rec_rd) rec_q <= rec_mem[bptr_q[CW-1:0]];
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.set_out) begin
      outcome_o <= cmd_i.out_code;
      entry_index_o <= cmd_i.store ? cnt_q[6:0] :
                       (cmd_i.out_rec ? 7'(bptr_q) : 7'd0);
      captured_count_o <= cmd_i.frame ? 8'd0 : (cmd_i.store ? cnt_q + 1'b1 : cnt_q);
      overflow_flag_o <= cmd_i.frame ? 1'b0 : (lost_q | cmd_i.set_lost);
    end
  end

  assign status_o.is_frame   = ~cmd_q;
  assign status_o.wrap       = (gen_inc == '0);
  assign status_o.clr_last   = (32'(clr_q) >= CLRN - 1);
  assign status_o.filt_hit   = (ftag_q == gen_q) && (fid_q == ident);
  assign status_o.hash_last  = (bidx_q == 4'd9);
  assign status_o.tag_live   = (btag_q == gen_q);
  assign status_o.full       = (32'(cnt_q) >= CAPACITY);
  assign status_o.probe_last = (32'(np_q) >= TABLE_SIZE - 1);
  assign status_o.rec_hit    = ptr_ok && (rec_q == {ident, s_q});

endmodule

// ===== sv/srdh_ctrl.sv =====
// Controller state machine sequencing filter, hash, probe and store.
`timescale 1ns / 1ps
module srdh_ctrl import srdh_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   ov_q, ov_d;
  logic   boot_q, boot_d;

  // Next state. After reset the tag memories are cleared once before any request.
  always_comb begin
    state_d = state_q;
    ov_d = ov_q;
    boot_d = boot_q;
    if (out_valid_o && out_ready_i) ov_d = 1'b0;
    case (state_q)
      StIdle: if (in_valid_i && !ov_q) state_d = StFiltRd;
      StFiltRd: begin
        if (status_i.is_frame) begin
          state_d = status_i.wrap ? StClear : StIdle;
          if (!status_i.wrap) ov_d = 1'b1;
        end else state_d = StFiltChk;
      end
      StClear: if (status_i.clr_last) begin
        state_d = StIdle;
        ov_d = !boot_q;
        boot_d = 1'b0;
      end
      StFiltChk: if (status_i.filt_hit) begin
        state_d = StIdle;
        ov_d = 1'b1;
      end else state_d = StHash;
      StHash: if (status_i.hash_last) state_d = StDone;
      StDone: state_d = StProbeRd;
      StProbeRd: state_d = StProbeTag;
      StProbeTag: begin
        if (!status_i.tag_live) begin
          state_d = StIdle;
          ov_d = 1'b1;
        end else state_d = StRecRd;
      end
      StRecRd: state_d = StRecChk;
      StRecChk: begin
        if (status_i.rec_hit || status_i.probe_last) begin
          state_d = StIdle;
          ov_d = 1'b1;
        end else state_d = StProbeRd;
      end
      default: state_d = StIdle;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o = '0;
    case (state_q)
      StIdle: cmd_o.load = in_valid_i && !ov_q;
      StFiltRd: begin
        if (status_i.is_frame) begin
          cmd_o.frame = 1'b1;
          cmd_o.set_out = !status_i.wrap;
          cmd_o.out_code = OutFrame;
        end else cmd_o.filt_rd = 1'b1;
      end
      StClear: begin
        cmd_o.clr_step = 1'b1;
        cmd_o.set_out = status_i.clr_last && !boot_q;
        cmd_o.out_code = OutFrame;
      end
      StFiltChk: begin
        if (status_i.filt_hit) begin
          cmd_o.set_out = 1'b1;
          cmd_o.out_code = OutSlot;
        end else cmd_o.filt_wr = 1'b1;
      end
      StHash: cmd_o.hash_step = 1'b1;
      StDone: cmd_o.probe_init = 1'b1;
      StProbeRd: cmd_o.probe_rd = 1'b1;
      StProbeTag: begin
        if (!status_i.tag_live) begin
          cmd_o.set_out = 1'b1;
          if (status_i.full) begin
            cmd_o.set_lost = 1'b1;
            cmd_o.out_code = OutLost;
          end else begin
            cmd_o.store = 1'b1;
            cmd_o.out_code = OutNew;
          end
        end else cmd_o.rec_rd = 1'b1;
      end
      StRecRd: ;
      StRecChk: begin
        if (status_i.rec_hit) begin
          cmd_o.set_out = 1'b1;
          cmd_o.out_code = OutFound;
          cmd_o.out_rec = 1'b1;
        end else if (status_i.probe_last) begin
          cmd_o.set_out = 1'b1;
          cmd_o.set_lost = 1'b1;
          cmd_o.out_code = OutLost;
        end else cmd_o.probe_next = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      ov_q <= 1'b0;
      boot_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ov_q <= ov_d;
      boot_q <= boot_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle) && !ov_q;
  assign out_valid_o = ov_q;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the sprite record dedup hash set.
`timescale 1ns / 1ps
module tb_top;
  import srdh_pkg::*;

  typedef struct {
    logic [15:0] y;
    logic [15:0] x;
    logic [15:0] attr;
    logic [7:0]  w;
    logic [7:0]  h;
    logic [7:0]  slot;
    logic [7:0]  chain;
  } sprite_t;

  typedef struct {
    logic [2:0] outcome;
    logic [6:0] index;
    logic [7:0] count;
    logic       ovf;
  } verdict_t;

  // Scoreboard: predicts the verdict for each accepted request and checks results.
  class dedup_scoreboard;
    logic [15:0] gen;
    int          n_entries;
    logic        lost;
    logic [15:0] bucket_gen[256];
    int          bucket_ptr[256];
    sprite_t     captured[128];
    logic [15:0] slot_gen[128];
    sprite_t     slot_seen[128];
    verdict_t    waiting[$];
    int          errors;
    int          seen_outcome[5];

    function new();
      gen = 16'd1;
      n_entries = 0;
      lost = 1'b0;
      errors = 0;
      foreach (bucket_gen[i]) begin
        bucket_gen[i] = '0;
        bucket_ptr[i] = 0;
      end
      foreach (slot_gen[i]) slot_gen[i] = '0;
      foreach (seen_outcome[i]) seen_outcome[i] = 0;
    endfunction

    function logic [31:0] fold_hash(sprite_t s);
      logic [7:0]  bytes[10];
      logic [31:0] hv;
      bytes = '{s.y[7:0], s.y[15:8], s.x[7:0], s.x[15:8], s.attr[7:0],
                s.attr[15:8], s.w, s.h, s.slot, s.chain};
      hv = FnvBasis;
      foreach (bytes[i]) hv = (hv ^ {24'd0, bytes[i]}) * FnvPrime;
      return hv ^ (hv >> 16);
    endfunction

    function bit same_sprite(sprite_t a, sprite_t b);
      return a.y == b.y && a.x == b.x && a.attr == b.attr && a.w == b.w &&
             a.h == b.h && a.chain == b.chain;
    endfunction

    function void push(logic [2:0] oc, int idx);
      verdict_t v;
      v.outcome = oc;
      v.index = idx[6:0];
      v.count = n_entries[7:0];
      v.ovf = lost;
      waiting.push_back(v);
    endfunction

    // Notes one accepted request and queues the verdict that it should produce.
    function void note_request(logic is_rec, sprite_t s);
      int fi;
      int pos;
      int p;
      if (!is_rec) begin
        n_entries = 0;
        lost = 1'b0;
        gen = gen + 16'd1;
        if (gen == 16'd0) begin
          foreach (bucket_gen[i]) bucket_gen[i] = '0;
          foreach (slot_gen[i]) slot_gen[i] = '0;
          gen = 16'd1;
        end
        push(OutFrame, 0);
        return;
      end
      fi = s.slot % 128;
      if (slot_gen[fi] == gen && same_sprite(slot_seen[fi], s)) begin
        push(OutSlot, 0);
        return;
      end
      slot_gen[fi] = gen;
      slot_seen[fi] = s;
      pos = fold_hash(s) % 256;
      for (int k = 0; k < 256; k++) begin
        if (bucket_gen[pos] != gen) begin
          if (n_entries >= 128) begin
            lost = 1'b1;
            push(OutLost, 0);
            return;
          end
          bucket_gen[pos] = gen;
          bucket_ptr[pos] = n_entries;
          captured[n_entries] = s;
          n_entries++;
          push(OutNew, n_entries - 1);
          return;
        end
        p = bucket_ptr[pos];
        if (p < 128 && same_sprite(captured[p], s) && captured[p].slot == s.slot) begin
          push(OutFound, p);
          return;
        end
        pos = (pos + 1) % 256;
      end
      lost = 1'b1;
      push(OutLost, 0);
    endfunction

    task report(string what, logic [7:0] got, logic [7:0] want);
      $display("ERROR %0t: %s got %0d, expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    // Compares one accepted result with the oldest outstanding verdict.
    task check_result(verdict_t got);
      verdict_t want;
      if (waiting.size() == 0) begin
        report("unexpected result, outcome", {5'd0, got.outcome}, 8'd0);
        return;
      end
      want = waiting.pop_front();
      if (want.outcome <= OutLost) seen_outcome[want.outcome]++;
      if (got.outcome !== want.outcome)
        report("outcome", {5'd0, got.outcome}, {5'd0, want.outcome});
      if (got.index !== want.index)
        report("entry_index", {1'b0, got.index}, {1'b0, want.index});
      if (got.count !== want.count) report("captured_count", got.count, want.count);
      if (got.ovf !== want.ovf) report("overflow_flag", {7'd0, got.ovf}, {7'd0, want.ovf});
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = 1'b0;
  logic [15:0] y_pos = '0, x_pos = '0, attributes = '0;
  logic [7:0]  width_cells = '0, height_cells = '0, table_slot = '0, chain_position = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  outcome;
  logic [6:0]  entry_index;
  logic [7:0]  captured_count;
  logic        overflow_flag;

  dedup_scoreboard sb = new();
  int  requests_sent = 0;
  int  burst_left = 0;
  bit  quick = 1'b0;
  bit  hold_toggle = 1'b0;
  bit  hold_seen = 1'b0;
  int  hold_left = 0;
  int  stall_mode = 0;
  int  mode_age = 0;

  sprite_record_dedup_hash_set DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .cmd_i(cmd), .y_pos_i(y_pos), .x_pos_i(x_pos), .attributes_i(attributes),
    .width_cells_i(width_cells), .height_cells_i(height_cells),
    .table_slot_i(table_slot), .chain_position_i(chain_position),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .outcome_o(outcome), .entry_index_o(entry_index),
    .captured_count_o(captured_count), .overflow_flag_o(overflow_flag)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Monitor: both handshakes are sampled at the rising edge.
  always @(posedge clk_i) begin
    sprite_t  s;
    verdict_t v;
    if (out_valid && out_ready) begin
      v.outcome = outcome;
      v.index = entry_index;
      v.count = captured_count;
      v.ovf = overflow_flag;
      sb.check_result(v);
    end
    if (in_valid && in_ready) begin
      s.y = y_pos; s.x = x_pos; s.attr = attributes; s.w = width_cells;
      s.h = height_cells; s.slot = table_slot; s.chain = chain_position;
      sb.note_request(cmd, s);
    end
  end

  // Receiver: its stall pattern is redrawn at random periodically; a toggle asks for a long hold.
  always @(posedge clk_i) begin
    mode_age <= mode_age + 1;
    if (mode_age % 64 == 63) stall_mode <= $urandom_range(0, 3);
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (quick || stall_mode == 0) begin
      out_ready <= 1'b1;
    end else if (stall_mode == 1) begin
      out_ready <= $urandom_range(0, 1);
    end else if (stall_mode == 2) begin
      out_ready <= ($urandom_range(0, 3) == 0);
    end else begin
      out_ready <= mode_age[2];
    end
  end

  function automatic sprite_t random_sprite();
    sprite_t s;
    s.y = $urandom; s.x = $urandom; s.attr = $urandom;
    s.w = $urandom; s.h = $urandom; s.slot = $urandom; s.chain = $urandom;
    return s;
  endfunction

  // Offers one request; the sender idles between bursts of random length.
  task automatic offer(logic is_rec, sprite_t s);
    if (!quick && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 30);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    cmd <= is_rec;
    y_pos <= s.y; x_pos <= s.x; attributes <= s.attr; width_cells <= s.w;
    height_cells <= s.h; table_slot <= s.slot; chain_position <= s.chain;
    do @(posedge clk_i); while (!in_ready);
    requests_sent++;
  endtask

  // Stops offering and waits until every outstanding verdict has arrived.
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.waiting.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    sprite_t zero_s, ones_s, other_s, s, last_s;
    sprite_t pool[$];
    int      pool_n, frame_len, pick;

    zero_s = '{16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    ones_s = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    other_s = zero_s;
    other_s.y = 16'h1234;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Directed: extremes, slot-filter hits, a table hit and a shared filter index.
    offer(1'b1, zero_s);
    offer(1'b1, zero_s);
    s = zero_s; s.slot = 8'd128;
    offer(1'b1, s);
    offer(1'b1, ones_s);
    offer(1'b1, other_s);
    offer(1'b1, zero_s);
    s = zero_s; s.slot = 8'd128;
    offer(1'b1, s);
    offer(1'b1, ones_s);
    offer(1'b0, ones_s);
    offer(1'b1, zero_s);
    offer(1'b1, zero_s);
    drain();

    // A new frame with no receiver stalls, then records from the frame before it.
    quick = 1'b1;
    offer(1'b0, random_sprite());
    offer(1'b1, other_s);
    offer(1'b1, ones_s);
    offer(1'b1, zero_s);
    quick = 1'b0;
    drain();

    // Random frames: mostly repeats from a per-frame pool, some noise.
    while (requests_sent < 1700) begin
      offer(1'b0, random_sprite());
      pool.delete();
      pool_n = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(2, 40);
      for (int i = 0; i < pool_n; i++) pool.push_back(random_sprite());
      frame_len = (pool_n > 100) ? 200 : 2 * pool_n;
      last_s = pool[0];
      for (int i = 0; i < frame_len; i++) begin
        pick = $urandom_range(0, 99);
        if (pool_n > 100) s = pool[i % pool_n];
        else if (pick < 50) s = pool[$urandom_range(0, pool_n - 1)];
        else if (pick < 65) s = last_s;
        else if (pick < 75) begin
          s = last_s;
          s.slot = s.slot ^ 8'h80;
        end else if (pick < 80) begin
          s = last_s;
          s.slot = s.slot + 8'd1;
        end else s = random_sprite();
        offer(1'b1, s);
        last_s = s;
        if (requests_sent % 300 == 0) hold_toggle <= ~hold_toggle;
      end
      if ($urandom_range(0, 9) == 0) drain();
    end
    drain();
    repeat (50) @(posedge clk_i);

    $display("Covered %0d requests: %0d frame starts, %0d new, %0d slot repeats,",
             requests_sent, sb.seen_outcome[0], sb.seen_outcome[1], sb.seen_outcome[2]);
    $display("%0d table hits and %0d lost records, with long output holds and drains.",
             sb.seen_outcome[3], sb.seen_outcome[4]);
    if (sb.errors == 0 && sb.waiting.size() == 0) begin
      $display("sprite_record_dedup_hash_set: match");
    end else begin
      $display("sprite_record_dedup_hash_set: mismatch");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20ms;
    $display("sprite_record_dedup_hash_set: mismatch");
    $finish;
  end

endmodule
